// ===== rtl/core/lprb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprb_pkg
// Shared sizes, codes and helpers of the length-prefixed record ring buffer.
// ----------------------------------------------------------------------------
package lprb_pkg;

    // ring storage
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;   // holds byte counts up to DEPTH
    localparam int CAP_W  = 11;           // capacity register width

    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(4);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

    // request modes
    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_PUT   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_NO_PUT  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT_HI,
        ST_HDR_LO,
        ST_HDR_HI,
        ST_DATA
    } t_state;

    // advance a ring index, wrapping at the active capacity
    function automatic logic [ADDR_W-1:0] bump(input logic [ADDR_W-1:0] idx,
                                               input logic [CAP_W-1:0]  cap);
        logic [CAP_W-1:0] nxt;
        nxt = CAP_W'(idx) + CAP_W'(1);
        return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
    endfunction

    // clamp a written capacity into the legal range
    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        if (v < CAP_MIN) begin
            return CAP_MIN;
        end else if (v > CAP_MAX) begin
            return CAP_MAX;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/lprb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lprb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/length_prefixed_record_ring_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_record_ring_buffer_top
// Byte ring holding records with a two-byte length header, one RAM port each
// for write and read, a small sequencer and a result register.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_stall    i_mode, i_record_length,
//                                                  i_data_byte
//  out       source     o_out_valid / i_out_stall  o_status, o_read_byte,
//                                                  o_last_byte, o_free_slots
//  cfg       sink       i_cfg_we                   i_cfg_data (capacity)
//
//  Put byte, refused requests and idle modes finish in ST_IDLE; begin put
//  also passes ST_PUT_HI (header high byte written on the one write port).
//  A read of an open record passes ST_DATA for the registered RAM output; a
//  read that starts a record first passes ST_HDR_LO and ST_HDR_HI (and may
//  end there, on the header); header bytes come through the same read port.
//  Reset is synchronous; no clearing pass, the RAM is read only where written.
//  A result waits in the output register; a new request is taken in the cycle
//  that register drains.
// ----------------------------------------------------------------------------
module length_prefixed_record_ring_buffer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_record_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_read_byte,
    output logic        o_last_byte,
    output logic [9:0]  o_free_slots,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data
);

    localparam int AW = lprb_pkg::ADDR_W;
    localparam int CW = lprb_pkg::CNT_W;
    localparam int PW = lprb_pkg::CAP_W;

    lprb_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_cap, n_cap;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [CW-1:0] r_held, n_held;     // bytes written and not yet read
    logic [CW-1:0] r_used, n_used;     // held plus bytes promised to open put
    logic [15:0]   r_put_rem, n_put_rem;
    logic [15:0]   r_get_rem, n_get_rem;
    logic          r_get_open, n_get_open;
    logic [7:0]    r_lo, n_lo;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;
    logic [9:0]    r_free, n_free;

    logic          mem_we, mem_re;
    logic [7:0]    mem_wdata, mem_rdata;

    logic          accept;
    logic          ld;
    logic [PW-1:0] room;
    logic [16:0]   need;
    logic [PW-1:0] free_next;
    logic [15:0]   hdr_len;

    // ring storage
    lprb_ram #(
        .WIDTH (8),
        .DEPTH (lprb_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_idx),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    // handshake
    assign o_in_stall = (r_state != lprb_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign room    = r_cap - PW'(1) - PW'(r_used);
    assign need    = {1'b0, i_record_length} + 17'd2;
    assign hdr_len = {mem_rdata, r_lo};

    // sequencer: next state, RAM controls and result
    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_held      = r_held;
        n_used      = r_used;
        n_put_rem   = r_put_rem;
        n_get_rem   = r_get_rem;
        n_get_open  = r_get_open;
        n_lo        = r_lo;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_byte      = r_byte;
        n_last      = r_last;
        n_free      = r_free;
        mem_we      = 1'b0;
        mem_wdata   = i_data_byte;
        mem_re      = 1'b0;
        ld          = 1'b0;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // result defaults, used whenever ld is set
        n_status = lprb_pkg::STAT_OK;
        n_byte   = '0;
        n_last   = 1'b0;
        if (!ld) begin
            n_status = r_status;
            n_byte   = r_byte;
            n_last   = r_last;
        end

        case (r_state)
            lprb_pkg::ST_IDLE: begin
                if (accept) begin
                    ld       = 1'b1;
                    n_status = lprb_pkg::STAT_OK;
                    n_byte   = '0;
                    n_last   = 1'b0;
                    case (i_mode)
                        lprb_pkg::MODE_BEGIN: begin
                            if (r_put_rem != '0 || {6'd0, room} < need) begin
                                n_status = lprb_pkg::STAT_NO_ROOM;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = i_record_length[7:0];
                                n_wr_idx  = lprb_pkg::bump(r_wr_idx, r_cap);
                                n_put_rem = i_record_length;
                                n_used    = r_used + i_record_length[CW-1:0] + CW'(2);
                                n_held    = r_held + CW'(1);
                                n_state   = lprb_pkg::ST_PUT_HI;
                            end
                        end
                        lprb_pkg::MODE_PUT: begin
                            if (r_put_rem == '0) begin
                                n_status = lprb_pkg::STAT_NO_PUT;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = i_data_byte;
                                n_wr_idx  = lprb_pkg::bump(r_wr_idx, r_cap);
                                n_put_rem = r_put_rem - 16'd1;
                                n_held    = r_held + CW'(1);
                            end
                        end
                        lprb_pkg::MODE_READ: begin
                            if (!r_get_open) begin
                                if (r_held < CW'(2)) begin
                                    n_status = lprb_pkg::STAT_EMPTY;
                                end else begin
                                    // fetch header low byte
                                    ld       = 1'b0;
                                    mem_re   = 1'b1;
                                    n_rd_idx = lprb_pkg::bump(r_rd_idx, r_cap);
                                    n_held   = r_held - CW'(1);
                                    n_used   = r_used - CW'(1);
                                    n_state  = lprb_pkg::ST_HDR_LO;
                                end
                            end else if (r_held == '0) begin
                                n_status = lprb_pkg::STAT_EMPTY;
                            end else begin
                                ld        = 1'b0;
                                mem_re    = 1'b1;
                                n_rd_idx  = lprb_pkg::bump(r_rd_idx, r_cap);
                                n_held    = r_held - CW'(1);
                                n_used    = r_used - CW'(1);
                                n_get_rem = r_get_rem - 16'd1;
                                n_state   = lprb_pkg::ST_DATA;
                            end
                        end
                        default: begin
                            n_status = lprb_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            lprb_pkg::ST_PUT_HI: begin
                // header high byte
                mem_we    = 1'b1;
                mem_wdata = r_put_rem[15:8];
                n_wr_idx  = lprb_pkg::bump(r_wr_idx, r_cap);
                n_held    = r_held + CW'(1);
                n_state   = lprb_pkg::ST_IDLE;
            end
            lprb_pkg::ST_HDR_LO: begin
                // low byte arrives, fetch high byte
                n_lo     = mem_rdata;
                mem_re   = 1'b1;
                n_rd_idx = lprb_pkg::bump(r_rd_idx, r_cap);
                n_held   = r_held - CW'(1);
                n_used   = r_used - CW'(1);
                n_state  = lprb_pkg::ST_HDR_HI;
            end
            lprb_pkg::ST_HDR_HI: begin
                n_state = lprb_pkg::ST_IDLE;
                if (hdr_len == '0) begin
                    // zero-length record finishes on its header
                    ld       = 1'b1;
                    n_status = lprb_pkg::STAT_OK;
                    n_byte   = '0;
                    n_last   = 1'b1;
                end else begin
                    n_get_open = 1'b1;
                    if (r_held == '0) begin
                        // payload not written yet, resume on a later read
                        ld        = 1'b1;
                        n_status  = lprb_pkg::STAT_EMPTY;
                        n_byte    = '0;
                        n_last    = 1'b0;
                        n_get_rem = hdr_len;
                    end else begin
                        mem_re    = 1'b1;
                        n_rd_idx  = lprb_pkg::bump(r_rd_idx, r_cap);
                        n_held    = r_held - CW'(1);
                        n_used    = r_used - CW'(1);
                        n_get_rem = hdr_len - 16'd1;
                        n_state   = lprb_pkg::ST_DATA;
                    end
                end
            end
            lprb_pkg::ST_DATA: begin
                // payload byte arrives
                ld       = 1'b1;
                n_status = lprb_pkg::STAT_OK;
                n_byte   = mem_rdata;
                n_last   = (r_get_rem == '0);
                if (r_get_rem == '0) begin
                    n_get_open = 1'b0;
                end
                n_state = lprb_pkg::ST_IDLE;
            end
            default: begin
                n_state = lprb_pkg::ST_IDLE;
            end
        endcase

        // free slots after this request
        free_next = r_cap - PW'(1) - PW'(n_used);
        if (ld) begin
            n_out_valid = 1'b1;
            n_free      = free_next[9:0];
        end else begin
            n_status = r_status;
            n_byte   = r_byte;
            n_last   = r_last;
        end

        // capacity write empties the ring
        if (i_cfg_we) begin
            n_cap      = lprb_pkg::clamp_cap(i_cfg_data);
            n_rd_idx   = '0;
            n_wr_idx   = '0;
            n_held     = '0;
            n_used     = '0;
            n_put_rem  = '0;
            n_get_rem  = '0;
            n_get_open = 1'b0;
            n_state    = lprb_pkg::ST_IDLE;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lprb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lprb_pkg::CAP_MAX;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_held      <= '0;
            r_used      <= '0;
            r_put_rem   <= '0;
            r_get_rem   <= '0;
            r_get_open  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap       <= n_cap;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_held      <= n_held;
            r_used      <= n_used;
            r_put_rem   <= n_put_rem;
            r_get_rem   <= n_get_rem;
            r_get_open  <= n_get_open;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_status <= n_status;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_free   <= n_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_byte  = r_byte;
    assign o_last_byte  = r_last;
    assign o_free_slots = r_free;

`ifndef NO_ASSERTIONS
    // a busy sequencer never takes a request
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lprb_pkg::ST_IDLE) |-> o_in_stall)
        else $error("request accepted while sequencer busy");

    // held bytes are always covered by the used count
    a_held_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_used)
        else $error("held bytes exceed used count");

    // one slot stays empty
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW'(r_used) < r_cap))
        else $error("used count reaches capacity");

    // a delayed read result never lands on a waiting result
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lprb_pkg::ST_DATA || r_state == lprb_pkg::ST_HDR_HI)
        |-> !r_out_valid)
        else $error("result register busy when read data returns");
`endif

endmodule
